[rtl/oamt_pkg.sv]
// Shared constants and command/status types for the owner allocation MRU table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package oamt_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [1:0] FUNC_ALLOC   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_CLOSE   = 2'd2;

	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
	} oamt_cmd_t;

	typedef struct packed {
		logic scan_last;
	} oamt_sts_t;

endpackage

[rtl/owner_allocation_mru_table.sv]
// Owner allocation MRU table: table of recent owners, a new owner inserted at the front, with period totals.
// Instantiates oamt_ctrl and oamt_dp; depends on oamt_pkg.
//
// Usage:
//   A request (func, owner_id, length) is taken on a rising edge with start high
//   and busy low. The block then scans the table one entry per cycle, applies
//   the update once the scan ends, and shows the result for exactly one cycle with
//   done high. peak_total, allocated_total and released_total hold their values
//   between requests; the other result fields hold until the next update.
//   Requests do not overlap: busy stays high through the scan and the update,
//   and the next request is taken only when busy is low.
//   busy falls in the result cycle, so the next request may be taken at the
//   edge that ends it.
//   The receiver cannot stall: the done strobe is not held, and the result fields change at the next update.
//   Reset clears all keys, byte counts and totals and sets entry i to color i.
`timescale 1ns / 1ps

module owner_allocation_mru_table import oamt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [15:0] owner_id,
	input  logic [23:0] length,
	output logic        done,
	output logic [31:0] peak_total,
	output logic [31:0] allocated_total,
	output logic [31:0] released_total,
	output logic        hit,
	output logic [2:0]  slot_index,
	output logic [31:0] slot_bytes,
	output logic [2:0]  slot_color,
	output logic        underflow
);

	oamt_cmd_t cmd;
	oamt_sts_t sts;

	oamt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	oamt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.owner_id        (owner_id),
		.length          (length),
		.peak_total      (peak_total),
		.allocated_total (allocated_total),
		.released_total  (released_total),
		.hit             (hit),
		.slot_index      (slot_index),
		.slot_bytes      (slot_bytes),
		.slot_color      (slot_color),
		.underflow       (underflow)
	);

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside end of request");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_under_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && underflow |-> hit)
		else $error("underflow flagged without a table hit");
`endif

endmodule

[rtl/oamt_ctrl.sv]
// Controller for the owner allocation MRU table: sequences load, scan and apply.
// Depends on oamt_pkg for the command and status structs.
`timescale 1ns / 1ps

module oamt_ctrl import oamt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  oamt_sts_t sts,
	output oamt_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign cmd.load  = (state_q == ST_IDLE) && start;
	assign cmd.scan  = (state_q == ST_SCAN);
	assign cmd.apply = (state_q == ST_APPLY);

endmodule

[rtl/oamt_dp.sv]
// Datapath for the owner allocation MRU table: table entries, scan pointer, totals.
// Depends on oamt_pkg for sizes, function codes and command/status structs.
`timescale 1ns / 1ps

module oamt_dp import oamt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  oamt_cmd_t   cmd,
	output oamt_sts_t   sts,
	input  logic [1:0]  func,
	input  logic [15:0] owner_id,
	input  logic [23:0] length,
	output logic [31:0] peak_total,
	output logic [31:0] allocated_total,
	output logic [31:0] released_total,
	output logic        hit,
	output logic [2:0]  slot_index,
	output logic [31:0] slot_bytes,
	output logic [2:0]  slot_color,
	output logic        underflow
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [15:0] keys_q   [TABLE_ENTRIES];
	logic [31:0] bytes_q  [TABLE_ENTRIES];
	logic [2:0]  colors_q [TABLE_ENTRIES];

	logic [31:0] peak_q, new_q, freed_q;

	logic [1:0]       func_q;
	logic [15:0]      key_q;
	logic [23:0]      len_q;
	logic [IDX_W-1:0] ptr_q;

	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [31:0]      match_bytes_q;
	logic [2:0]       match_color_q;
	logic             vic_found_q;
	logic [IDX_W-1:0] vic_idx_q;
	logic [2:0]       vic_color_q;

	logic        res_hit_q;
	logic [2:0]  res_idx_q;
	logic [31:0] res_bytes_q;
	logic [2:0]  res_color_q;
	logic        res_under_q;

	logic [31:0] len_ext;
	logic [31:0] add_bytes;
	logic [31:0] sub_bytes;
	logic        rel_under;
	logic [31:0] rel_bytes;

	assign len_ext   = {8'd0, len_q};
	assign add_bytes = match_bytes_q + len_ext;
	assign sub_bytes = match_bytes_q - len_ext;
	assign rel_under = (len_ext > match_bytes_q);
	assign rel_bytes = rel_under ? 32'd0 : sub_bytes;

	assign sts.scan_last = (ptr_q == LAST_IDX);

	// scan and request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q        <= FUNC_CLOSE;
			key_q         <= '0;
			len_q         <= '0;
			ptr_q         <= '0;
			match_found_q <= 1'b0;
			match_idx_q   <= '0;
			match_bytes_q <= '0;
			match_color_q <= '0;
			vic_found_q   <= 1'b0;
			vic_idx_q     <= '0;
			vic_color_q   <= '0;
		end else if (cmd.load) begin
			func_q        <= func;
			key_q         <= owner_id;
			len_q         <= length;
			ptr_q         <= '0;
			match_found_q <= 1'b0;
			vic_found_q   <= 1'b0;
		end else if (cmd.scan) begin
			if (!match_found_q && keys_q[ptr_q] == key_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= ptr_q;
				match_bytes_q <= bytes_q[ptr_q];
				match_color_q <= colors_q[ptr_q];
			end
			if (!vic_found_q && (bytes_q[ptr_q] == 32'd0 || ptr_q == LAST_IDX)) begin
				vic_found_q <= 1'b1;
				vic_idx_q   <= ptr_q;
				vic_color_q <= colors_q[ptr_q];
			end
			if (ptr_q != LAST_IDX) ptr_q <= ptr_q + 1'b1;
		end
	end

	// table, totals and result update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TABLE_ENTRIES; j++) begin
				keys_q[j]   <= '0;
				bytes_q[j]  <= '0;
				colors_q[j] <= 3'(j);
			end
			peak_q      <= '0;
			new_q       <= '0;
			freed_q     <= '0;
			res_hit_q   <= 1'b0;
			res_idx_q   <= '0;
			res_bytes_q <= '0;
			res_color_q <= '0;
			res_under_q <= 1'b0;
		end else if (cmd.apply) begin
			res_hit_q   <= 1'b0;
			res_idx_q   <= '0;
			res_bytes_q <= '0;
			res_color_q <= '0;
			res_under_q <= 1'b0;
			case (func_q)
				FUNC_ALLOC: begin
					peak_q <= peak_q + len_ext;
					new_q  <= new_q + len_ext;
					if (match_found_q) begin
						bytes_q[match_idx_q] <= add_bytes;
						res_hit_q   <= 1'b1;
						res_idx_q   <= 3'(match_idx_q);
						res_bytes_q <= add_bytes;
						res_color_q <= match_color_q;
					end else begin
						for (int j = 1; j < TABLE_ENTRIES; j++) begin
							if (IDX_W'(j) <= vic_idx_q) begin
								keys_q[j]   <= keys_q[j-1];
								bytes_q[j]  <= bytes_q[j-1];
								colors_q[j] <= colors_q[j-1];
							end
						end
						keys_q[0]   <= key_q;
						bytes_q[0]  <= len_ext;
						colors_q[0] <= vic_color_q;
						res_bytes_q <= len_ext;
						res_color_q <= vic_color_q;
					end
				end
				FUNC_RELEASE: begin
					freed_q <= freed_q + len_ext;
					if (match_found_q) begin
						bytes_q[match_idx_q] <= rel_bytes;
						res_hit_q   <= 1'b1;
						res_idx_q   <= 3'(match_idx_q);
						res_bytes_q <= rel_bytes;
						res_color_q <= match_color_q;
						res_under_q <= rel_under;
					end
				end
				FUNC_CLOSE: begin
					peak_q  <= peak_q - freed_q;
					new_q   <= '0;
					freed_q <= '0;
				end
				default: begin
					peak_q <= peak_q;
				end
			endcase
		end
	end

	assign peak_total      = peak_q;
	assign allocated_total = new_q;
	assign released_total  = freed_q;
	assign hit             = res_hit_q;
	assign slot_index      = res_idx_q;
	assign slot_bytes      = res_bytes_q;
	assign slot_color      = res_color_q;
	assign underflow       = res_under_q;

endmodule
